>>> rtl/sitp_pkg.sv
// shared types, constants and character helpers for the saturating integer text parser
`default_nettype none

package sitp_pkg;

    localparam int MagWidth   = 63;
    localparam int ValueWidth = 64;
    localparam int BaseWidth  = 5;
    localparam int CfgWidth   = 6;
    localparam int SumWidth   = MagWidth + 5;

    localparam logic [CfgWidth-1:0]  NumberBaseReset = 6'd10;
    localparam logic [CfgWidth-1:0]  CfgBaseAuto     = 6'd0;
    localparam logic [CfgWidth-1:0]  CfgBaseOct      = 6'd8;
    localparam logic [CfgWidth-1:0]  CfgBaseDec      = 6'd10;
    localparam logic [CfgWidth-1:0]  CfgBaseHex      = 6'd16;

    localparam logic [BaseWidth-1:0] BaseNone = 5'd0;
    localparam logic [BaseWidth-1:0] BaseOct  = 5'd8;
    localparam logic [BaseWidth-1:0] BaseDec  = 5'd10;
    localparam logic [BaseWidth-1:0] BaseHex  = 5'd16;

    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChVt    = 8'h0B;
    localparam logic [7:0] ChFf    = 8'h0C;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChZero  = 8'h30;
    localparam logic [7:0] ChNine  = 8'h39;
    localparam logic [7:0] ChLowA  = 8'h61;
    localparam logic [7:0] ChLowF  = 8'h66;
    localparam logic [7:0] ChUpA   = 8'h41;
    localparam logic [7:0] ChUpF   = 8'h46;
    localparam logic [7:0] ChLowX  = 8'h78;
    localparam logic [7:0] ChUpX   = 8'h58;

    localparam logic [ValueWidth-1:0] PosMax = {1'b0, {(ValueWidth-1){1'b1}}};
    localparam logic [ValueWidth-1:0] NegMin = {1'b1, {(ValueWidth-1){1'b0}}};

    typedef enum logic [3:0] {
        PH_SPACE  = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_DIGITS = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic                  negative;
        logic [MagWidth-1:0]   magnitude;
        logic [BaseWidth-1:0]  active_base;
        logic                  overflowed;
    } parse_state_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] ch;
    } char_word_t;

    typedef struct packed {
        logic                          consumed;
        logic                          done_res;
        logic signed [ValueWidth-1:0]  value;
        logic                          overflow;
    } result_word_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } digit_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == ChSpace) || (c == ChTab) || (c == ChLf) ||
               (c == ChCr) || (c == ChFf) || (c == ChVt);
    endfunction

    function automatic digit_t digit_of(input logic [7:0] c, input logic [BaseWidth-1:0] base);
        digit_t     r;
        logic [7:0] d;
        logic       hit;
        hit = 1'b1;
        d   = 8'd0;
        if (c >= ChZero && c <= ChNine)
            d = c - ChZero;
        else if (c >= ChLowA && c <= ChLowF)
            d = c - ChLowA + 8'd10;
        else if (c >= ChUpA && c <= ChUpF)
            d = c - ChUpA + 8'd10;
        else
            hit = 1'b0;
        r.val = d[3:0];
        case (base)
            BaseHex: r.ok = hit;
            BaseOct: r.ok = hit && (d < 8'd8);
            BaseDec: r.ok = hit && (d < 8'd10);
            default: r.ok = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sitp_step.sv
// next parse state and consume flag for one character
`default_nettype none

module sitp_step
    import sitp_pkg::*;
(
    input  wire parse_state_t          cur,
    input  wire char_word_t            word,
    input  wire logic [CfgWidth-1:0]   number_base,
    output parse_state_t               nxt,
    output logic                       took
);

    logic                 cont;
    logic                 sign_seen;
    digit_t               dg;
    logic [SumWidth-1:0]  mag_ext;
    logic [SumWidth-1:0]  sum;
    logic                 base_ok;

    assign base_ok = (number_base == CfgBaseOct) || (number_base == CfgBaseDec) ||
                     (number_base == CfgBaseHex);

    always_comb
    begin
        nxt       = cur;
        took      = 1'b0;
        cont      = 1'b1;
        sign_seen = 1'b0;
        dg        = '0;
        sum       = '0;
        mag_ext   = '0;
        if (word.start_req)
        begin
            nxt.phase       = PH_SPACE;
            nxt.negative    = 1'b0;
            nxt.magnitude   = '0;
            nxt.active_base = BaseNone;
            nxt.overflowed  = 1'b0;
        end

        // leading whitespace and sign, base latched on leaving
        if (nxt.phase == PH_SPACE)
        begin
            if (is_space(word.ch))
            begin
                took = 1'b1;
                cont = 1'b0;
            end
            else
            begin
                if (word.ch == ChMinus || word.ch == ChPlus)
                begin
                    sign_seen    = 1'b1;
                    nxt.negative = (word.ch == ChMinus);
                    took         = 1'b1;
                    cont         = 1'b0;
                end
                if (number_base == CfgBaseAuto)
                begin
                    nxt.phase       = PH_PREFIX;
                    nxt.active_base = BaseNone;
                end
                else
                begin
                    nxt.phase       = PH_DIGITS;
                    nxt.active_base = base_ok ? number_base[BaseWidth-1:0] : BaseNone;
                end
            end
        end

        // base detection
        if (cont && !sign_seen && nxt.phase == PH_PREFIX)
        begin
            if (nxt.active_base == BaseNone)
            begin
                if (word.ch == ChZero)
                begin
                    nxt.active_base = BaseOct;
                    took            = 1'b1;
                    cont            = 1'b0;
                end
                else
                begin
                    nxt.active_base = BaseDec;
                    nxt.phase       = PH_DIGITS;
                end
            end
            else
            begin
                nxt.phase = PH_DIGITS;
                if (word.ch == ChLowX || word.ch == ChUpX)
                begin
                    nxt.active_base = BaseHex;
                    took            = 1'b1;
                    cont            = 1'b0;
                end
            end
        end

        // digit accumulation with overflow check on the widened sum
        if (cont && nxt.phase == PH_DIGITS)
        begin
            dg      = digit_of(word.ch, nxt.active_base);
            mag_ext = {{(SumWidth-MagWidth){1'b0}}, nxt.magnitude};
            case (nxt.active_base)
                BaseOct: sum = (mag_ext << 3);
                BaseDec: sum = (mag_ext << 3) + (mag_ext << 1);
                BaseHex: sum = (mag_ext << 4);
                default: sum = '0;
            endcase
            sum = sum + {{(SumWidth-4){1'b0}}, dg.val};
            if (!dg.ok)
                nxt.phase = PH_DONE;
            else if (|sum[SumWidth-1:MagWidth])
            begin
                nxt.overflowed = 1'b1;
                nxt.phase      = PH_DONE;
            end
            else
            begin
                nxt.magnitude = sum[MagWidth-1:0];
                took          = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/saturating_integer_text_parser.sv
// top level of the saturating integer text parser: handshake, config port and state
//
// char channel: one character word (start_req, ch) per handshake; a word is
// taken at a rising edge with char_valid high and char_stall low. result
// channel: one result word (consumed, done_res, value, overflow) per character,
// in order, taken when result_valid is high and result_stall is low.
// a taken word is parsed between the input register and the result register
// and shows on the result channel once the result register takes it; one word
// per cycle sustained while result_stall is low. the per-character path is one
// 68-bit shift-and-add with its overflow test, which sets the cycle time.
// while result_stall is high the result word holds; the input register still
// fills once, then char_stall rises until the result side drains.
// number_base is written over the apb port at byte address 0 and latched per
// string when leading whitespace ends; pready is always high.
// reset clears both registers' valid flags, the parse state (whitespace phase,
// value 0) and sets number_base to 10.
`default_nettype none

module saturating_integer_text_parser
    import sitp_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          char_valid,
    output logic               char_stall,
    input  wire char_word_t    char_word,
    output logic               result_valid,
    input  wire logic          result_stall,
    output result_word_t       result_word,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [1:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [CfgWidth-1:0]  number_base_reg;
    logic                 s1_valid_reg;
    char_word_t           s1_word_reg;
    parse_state_t         state_reg;
    parse_state_t         state_next;
    logic                 took_next;
    logic                 consumed_reg;
    logic                 done_reg;
    logic                 negative_reg;
    logic                 overflow_reg;
    logic [MagWidth-1:0]  magnitude_reg;
    logic                 advance;
    logic                 accept;
    logic [ValueWidth-1:0] mag_wide;
    logic [ValueWidth-1:0] value_bits;

    assign pready = 1'b1;
    assign prdata = {{(32-CfgWidth){1'b0}}, number_base_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            number_base_reg <= NumberBaseReset;
        else if (psel && penable && pwrite && (paddr == 2'd0))
            number_base_reg <= pwdata[CfgWidth-1:0];
    end

    assign advance    = !result_valid || !result_stall;
    assign char_stall = s1_valid_reg && !advance;
    assign accept     = char_valid && !char_stall;

    sitp_step u_step
    (
        .cur         (state_reg),
        .word        (s1_word_reg),
        .number_base (number_base_reg),
        .nxt         (state_next),
        .took        (took_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            result_valid <= 1'b0;
            state_reg    <= '{phase: PH_SPACE, negative: 1'b0, magnitude: '0,
                              active_base: BaseNone, overflowed: 1'b0};
        end
        else
        begin
            if (advance)
            begin
                result_valid <= s1_valid_reg;
                if (s1_valid_reg)
                    state_reg <= state_next;
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_word_reg <= char_word;
        if (advance && s1_valid_reg)
        begin
            consumed_reg  <= took_next;
            done_reg      <= (state_next.phase == PH_DONE);
            negative_reg  <= state_next.negative;
            overflow_reg  <= state_next.overflowed;
            magnitude_reg <= state_next.magnitude;
        end
    end

    assign mag_wide = {1'b0, magnitude_reg};

    always_comb
    begin
        if (overflow_reg)
            value_bits = negative_reg ? NegMin : PosMax;
        else if (negative_reg)
            value_bits = ~mag_wide + {{(ValueWidth-1){1'b0}}, 1'b1};
        else
            value_bits = mag_wide;
    end

    assign result_word.consumed = consumed_reg;
    assign result_word.done_res = done_reg;
    assign result_word.value    = value_bits;
    assign result_word.overflow = overflow_reg;

    // a consumed character never comes with a saturated value
    a_consumed_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.consumed |-> !result_word.overflow)
        else $error("consumed character reported with overflow");

    a_ovf_done: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_word.overflow |-> result_word.done_res)
        else $error("overflow without end of parse");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> s1_valid_reg && result_valid)
        else $error("input stalled with free input register");

    a_prefix_base: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_PREFIX |->
            (state_reg.active_base == BaseNone || state_reg.active_base == BaseOct))
        else $error("bad base while detecting prefix");

endmodule

`default_nettype wire

>>> test/sitp_checker.sv
// checker for the saturating integer text parser: tracks the base register, predicts and compares result words
`timescale 1ns / 100ps

module sitp_checker
    import sitp_pkg::*;
#(
    parameter logic [1:0] BaseAddr = 2'd0
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    input  logic         char_stall,
    input  char_word_t   char_word,
    input  logic         result_valid,
    input  logic         result_stall,
    input  result_word_t result_word,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic [31:0]  prdata,
    input  logic         pready,
    output int           fail_count,
    output int           words_due
);

    logic [CfgWidth-1:0]  base_reg = NumberBaseReset;
    phase_t               parse_phase = PH_SPACE;
    logic                 is_negative = 1'b0;
    logic [MagWidth-1:0]  mag = '0;
    logic [BaseWidth-1:0] cur_base = BaseNone;
    logic                 saturated = 1'b0;
    result_word_t         expected_words[$];
    result_word_t         exp_word;
    result_word_t         got_word;

    initial
    begin
        fail_count = 0;
        words_due  = 0;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == ChSpace || c == ChTab || c == ChLf || c == ChCr || c == ChFf || c == ChVt;
    endfunction

    function automatic int digit_weight(input logic [7:0] c, input logic [BaseWidth-1:0] b);
        int d;
        if (c >= ChZero && c <= ChNine)
            d = int'(c) - int'(ChZero);
        else if (c >= ChLowA && c <= ChLowF)
            d = int'(c) - int'(ChLowA) + 10;
        else if (c >= ChUpA && c <= ChUpF)
            d = int'(c) - int'(ChUpA) + 10;
        else
            return -1;
        if (b == BaseHex)
            return d;
        if (b == BaseOct && d < 8)
            return d;
        if (b == BaseDec && d < 10)
            return d;
        return -1;
    endfunction

    function automatic void clear_parse();
        parse_phase = PH_SPACE;
        is_negative = 1'b0;
        mag         = '0;
        cur_base    = BaseNone;
        saturated   = 1'b0;
    endfunction

    // leaving whitespace: the base register is sampled here
    function automatic void latch_base();
        if (base_reg == CfgBaseAuto)
        begin
            parse_phase = PH_PREFIX;
            cur_base    = BaseNone;
        end
        else
        begin
            parse_phase = PH_DIGITS;
            if (base_reg == CfgBaseOct || base_reg == CfgBaseDec || base_reg == CfgBaseHex)
                cur_base = base_reg[BaseWidth-1:0];
            else
                cur_base = BaseNone;
        end
    endfunction

    function automatic logic take_char(input logic [7:0] c);
        int              d;
        logic [63:0]     limit;
        logic [63:0]     next_mag;
        if (parse_phase == PH_SPACE)
        begin
            if (is_blank(c))
                return 1'b1;
            if (c == ChMinus || c == ChPlus)
            begin
                is_negative = (c == ChMinus);
                latch_base();
                return 1'b1;
            end
            latch_base();
        end
        if (parse_phase == PH_PREFIX)
        begin
            if (cur_base == BaseNone)
            begin
                if (c == ChZero)
                begin
                    cur_base = BaseOct;
                    return 1'b1;
                end
                cur_base    = BaseDec;
                parse_phase = PH_DIGITS;
            end
            else
            begin
                parse_phase = PH_DIGITS;
                if (c == ChLowX || c == ChUpX)
                begin
                    cur_base = BaseHex;
                    return 1'b1;
                end
            end
        end
        if (parse_phase == PH_DIGITS)
        begin
            d = digit_weight(c, cur_base);
            if (d < 0)
            begin
                parse_phase = PH_DONE;
                return 1'b0;
            end
            limit = (PosMax - 64'(d)) / 64'(cur_base);
            if ({1'b0, mag} > limit)
            begin
                saturated   = 1'b1;
                parse_phase = PH_DONE;
                return 1'b0;
            end
            next_mag = {1'b0, mag} * 64'(cur_base) + 64'(d);
            mag      = next_mag[MagWidth-1:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_word_t parse_char(input char_word_t w);
        result_word_t r;
        if (w.start_req)
            clear_parse();
        r.consumed = take_char(w.ch);
        r.done_res = (parse_phase == PH_DONE);
        if (saturated)
            r.value = is_negative ? NegMin : PosMax;
        else
            r.value = is_negative ? -{1'b0, mag} : {1'b0, mag};
        r.overflow = saturated;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg = NumberBaseReset;
            clear_parse();
            expected_words.delete();
            words_due = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == BaseAddr)
            begin
                if (pwrite)
                    base_reg = pwdata[CfgWidth-1:0];
                else if (prdata !== 32'(base_reg))
                begin
                    $display("%0t number_base readback: expected %0d actual %0d",
                             $time, base_reg, prdata);
                    fail_count++;
                end
            end
            if (result_valid && !result_stall)
            begin
                got_word = result_word;
                if (expected_words.size() == 0)
                begin
                    $display("%0t unexpected result word: expected none actual %h",
                             $time, got_word);
                    fail_count++;
                end
                else
                begin
                    exp_word = expected_words.pop_front();
                    if (got_word.consumed !== exp_word.consumed)
                    begin
                        $display("%0t consumed: expected %0b actual %0b",
                                 $time, exp_word.consumed, got_word.consumed);
                        fail_count++;
                    end
                    if (got_word.done_res !== exp_word.done_res)
                    begin
                        $display("%0t done_res: expected %0b actual %0b",
                                 $time, exp_word.done_res, got_word.done_res);
                        fail_count++;
                    end
                    if (got_word.value !== exp_word.value)
                    begin
                        $display("%0t value: expected %0d actual %0d",
                                 $time, exp_word.value, got_word.value);
                        fail_count++;
                    end
                    if (got_word.overflow !== exp_word.overflow)
                    begin
                        $display("%0t overflow: expected %0b actual %0b",
                                 $time, exp_word.overflow, got_word.overflow);
                        fail_count++;
                    end
                end
            end
            if (char_valid && !char_stall)
                expected_words.push_back(parse_char(char_word));
            words_due = expected_words.size();
        end
    end

endmodule

>>> test/tb.sv
// testbench top for the saturating integer text parser: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb;
    import sitp_pkg::*;

    localparam logic [1:0] NumberBaseAddr = 2'd0;
    localparam int SegmentItems = 50;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         char_valid = 1'b0;
    logic         char_stall;
    char_word_t   char_word = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    result_word_t result_word;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [1:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           words_due;

    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           sent_chars = 0;
    int           seg_end;
    logic [5:0]   base_pick;
    logic [7:0]   text_chars[$];

    saturating_integer_text_parser uut (.*);

    sitp_checker #(.BaseAddr(NumberBaseAddr)) result_check (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    task automatic push_char(input logic start, input logic [7:0] c);
        char_word_t w;
        w.start_req = start;
        w.ch        = c;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid <= 1'b1;
        char_word  <= w;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        sent_chars++;
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_chars.push_back(s[i]);
    endtask

    // first character of the buffer carries start_req
    task automatic push_text();
        foreach (text_chars[i])
            push_char(i == 0, text_chars[i]);
        text_chars.delete();
    endtask

    task automatic settle();
        char_valid <= 1'b0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [5:0] b);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NumberBaseAddr;
        pwdata  <= 32'(b);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        // read back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 5))
            0: return ChSpace;
            1: return ChTab;
            2: return ChLf;
            3: return ChCr;
            4: return ChFf;
            default: return ChVt;
        endcase
    endfunction

    function automatic logic [7:0] rand_digit(input logic [4:0] b);
        int d;
        d = $urandom_range(0, int'(b) - 1);
        if (d < 10)
            return ChZero + 8'(d);
        if ($urandom_range(0, 1))
            return ChLowA + 8'(d - 10);
        return ChUpA + 8'(d - 10);
    endfunction

    task automatic random_string(input logic [5:0] b);
        logic [4:0] eff;
        int         kind;
        eff = BaseDec;
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 8))
                push_char($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(0, 3))
            text_chars.push_back(rand_blank());
        case ($urandom_range(0, 3))
            0: text_chars.push_back(ChMinus);
            1: text_chars.push_back(ChPlus);
            default: ;
        endcase
        if (b == CfgBaseAuto)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    add_str("0x");
                    eff = BaseHex;
                end
                1:
                begin
                    add_str("0X");
                    eff = BaseHex;
                end
                2:
                begin
                    add_str("0");
                    eff = BaseOct;
                end
                default: eff = BaseDec;
            endcase
        end
        else if (b == CfgBaseOct || b == CfgBaseDec || b == CfgBaseHex)
            eff = b[4:0];
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            // largest value, then up to two digits that push past it
            if (eff == BaseHex)
                add_str("7fffffffffffffff");
            else if (eff == BaseOct)
                add_str("777777777777777777777");
            else
                add_str("9223372036854775807");
            repeat ($urandom_range(0, 2))
                text_chars.push_back(rand_digit(eff));
        end
        else if (kind < 4)
            repeat ($urandom_range(15, 24))
                text_chars.push_back(rand_digit(eff));
        else
            repeat ($urandom_range(0, 8))
                text_chars.push_back(rand_digit(eff));
        case ($urandom_range(0, 3))
            0: text_chars.push_back(8'h00);
            1: text_chars.push_back(8'($urandom_range(0, 255)));
            2:
            begin
                text_chars.push_back(8'($urandom_range(0, 255)));
                text_chars.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        if (text_chars.size() == 0)
            text_chars.push_back(8'($urandom_range(0, 255)));
        push_text();
    endtask

    initial
    begin
        #20_000_000;
        $display("saturating_integer_text_parser: mismatch");
        $finish;
    end

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all six blanks, sign, digits, then a non-digit and an ignored char
        text_chars.push_back(ChSpace);
        text_chars.push_back(ChTab);
        text_chars.push_back(ChLf);
        text_chars.push_back(ChCr);
        text_chars.push_back(ChFf);
        text_chars.push_back(ChVt);
        add_str("-90x5");
        push_text();
        // sign then terminator
        add_str("+");
        text_chars.push_back(8'h00);
        push_text();

        // explicit hex takes mixed-case digits and stops at the x
        write_base(CfgBaseHex);
        add_str("0fAx");
        text_chars.push_back(8'hFF);
        push_text();

        // detected hex, then prefix with no digits
        write_base(CfgBaseAuto);
        add_str("0Xf");
        text_chars.push_back(8'h80);
        push_text();
        add_str("-0xz");
        push_text();

        // unsupported base
        write_base(6'd36);
        add_str(" -1");
        push_text();

        // base stays latched across a register write
        write_base(CfgBaseOct);
        add_str("7");
        push_text();
        write_base(CfgBaseDec);
        push_char(1'b0, "9");

        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 65;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 65;
                end
                default:
                begin
                    send_idle_pct = 36;
                    stall_pct     = 36;
                end
            endcase
            for (int seg = 0; seg < 6; seg++)
            begin
                if (seg == 0)
                    base_pick = CfgBaseAuto;
                else if (seg == 1)
                    base_pick = 6'd36;
                else
                begin
                    case ($urandom_range(0, 7))
                        0: base_pick = CfgBaseAuto;
                        1: base_pick = CfgBaseOct;
                        2: base_pick = CfgBaseDec;
                        3: base_pick = CfgBaseHex;
                        4: base_pick = 6'($urandom_range(0, 36));
                        5: base_pick = CfgBaseAuto;
                        6: base_pick = CfgBaseHex;
                        default: base_pick = CfgBaseDec;
                    endcase
                end
                write_base(base_pick);
                seg_end = sent_chars + SegmentItems;
                while (sent_chars < seg_end)
                    random_string(base_pick);
            end
        end

        settle();
        repeat (8)
            @(posedge clk);
        if (fail_count == 0)
            $display("saturating_integer_text_parser: match");
        else
            $display("saturating_integer_text_parser: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/sitp_pkg.sv
rtl/sitp_step.sv
rtl/saturating_integer_text_parser.sv
test/sitp_checker.sv
test/tb.sv
